### design/cfd_pkg.sv
// Shared types and constants of the command frame decoder.
`default_nettype none
package cfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned HDR_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = KIND_W + INDEX_W + VALUE_W;
  localparam int unsigned NUM_CODES = 8;

  // Command kinds, in priority order
  localparam logic [KIND_W-1:0] KIND_HOME     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_MAPPING  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RUN      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_REQUEST  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SEND     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_MOTOR    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_WELDER   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FEEDBACK = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CODES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FEEDBACK = 2'd2;

  // Frame offsets, counted from the first header byte
  localparam logic [OFFSET_W-1:0] OFF_CODE         = 7'd3;
  localparam logic [OFFSET_W-1:0] OFF_FIRST        = 7'd4;
  localparam logic [OFFSET_W-1:0] OFF_MOVE_VAL     = 7'd6;
  localparam logic [OFFSET_W-1:0] OFF_MOVE_END     = 7'd13;
  localparam logic [OFFSET_W-1:0] OFF_SEND_DBL_END = 7'd75;
  localparam logic [OFFSET_W-1:0] OFF_SEND_GAP     = 7'd76;
  localparam logic [OFFSET_W-1:0] OFF_SEND_POINT   = 7'd77;
  localparam logic [OFFSET_W-1:0] OFF_SEND_PATTERN = 7'd78;

  // Fixed field numbers
  localparam logic [INDEX_W-1:0] IDX_NONE        = 4'd0;
  localparam logic [INDEX_W-1:0] IDX_MOVE_VAL    = 4'd2;
  localparam logic [INDEX_W-1:0] IDX_SEND_POINT  = 4'd9;
  localparam logic [INDEX_W-1:0] IDX_SEND_PATTERN = 4'd10;
  localparam logic [INDEX_W-1:0] IDX_SEND_SPEED  = 4'd11;

  // One result record from the parser to the output register
  typedef struct packed {
    logic                emit;
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } cfd_result_t;

  // Byte held in the input register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } cfd_byte_t;

endpackage
`default_nettype wire

### design/command_frame_decoder_core.sv
// Top level of the command frame decoder.
//
// Takes one received byte per clock on the in_ stream and decodes command
// frames: three configured header bytes, a command code byte matched against
// nine configured codes (first match wins), then the command's payload.
// Each payload field is sent on the out_ stream when its last byte arrives,
// with tlast on the final field of the frame; commands without a payload give
// one record at the code byte. A byte waits in the input register and is
// decoded into the output register when the decode step advances; one byte
// per cycle is sustained while the consumer keeps up, a figure set by the
// single decode step between the two registers. A result that waits on
// out_tready holds the decode step, so the input register takes at most one
// more byte until the result drains. Configuration is written on the cfg_
// port (always ready); the user must write it only while idle, as the block
// does not enforce this.
`default_nettype none
module command_frame_decoder_core
  import cfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] command_kind, [7:4] field_index,
                                                 // [71:8] field_value
  output logic                       out_tlast,  // last_field
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfd_byte_t   held;
  cfd_result_t result;
  logic        advance;

  assign cfg_ready = 1'b1;

  // Decode the held byte when the output register is free or draining
  assign advance = held.valid && (!out_tvalid || out_tready);

  cfd_input_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .held      (held)
  );

  cfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .rx_byte   (held.data),
    .result    (result)
  );

  cfd_output_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### design/cfd_input_stage.sv
// Input register: holds one received byte until the parser takes it.
`default_nettype none
module cfd_input_stage
  import cfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  input  wire logic              advance,
  output cfd_byte_t              held
);

  logic              valid_r;
  logic [BYTE_W-1:0] data_r;

  // Free slot, or the held byte moves on this cycle
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign held.valid = valid_r;
  assign held.data  = data_r;

endmodule
`default_nettype wire

### design/cfd_parser.sv
// Frame parser: header hunt, code decode, payload field assembly, config registers.
`default_nettype none
module cfd_parser
  import cfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  advance,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output cfd_result_t                result
);

  typedef enum logic [2:0] {
    ST_H1   = 3'd0,
    ST_H2   = 3'd1,
    ST_H3   = 3'd2,
    ST_CODE = 3'd3,
    ST_PAY  = 3'd4
  } stage_t;

  // Configuration
  logic [HDR_W-1:0]      header_r;
  logic [VALUE_W-1:0]    codes_r;
  logic [BYTE_W-1:0]     fb_code_r;

  // Parse state
  stage_t                stage_r, stage_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [INDEX_W-1:0]    fcount_r, fcount_nxt;
  logic [VALUE_W-1:0]    acc_r, acc_nxt;

  logic [BYTE_W-1:0]     hdr0, hdr1, hdr2;
  logic                  restart_hit;
  stage_t                restart_stage;
  logic [VALUE_W-1:0]    acc_shift;
  logic [VALUE_W-1:0]    byte_ext;
  logic [NUM_CODES-1:0]  code_hit;
  logic                  code_found;
  logic [KIND_W-1:0]     code_kind;
  logic [OFFSET_W-1:0]   dbl_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= '0;
      codes_r   <= '0;
      fb_code_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_HEADER:   header_r  <= cfg_data[HDR_W-1:0];
        CFG_IDX_CODES:    codes_r   <= cfg_data;
        CFG_IDX_FEEDBACK: fb_code_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign hdr0 = header_r[23:16];
  assign hdr1 = header_r[15:8];
  assign hdr2 = header_r[7:0];

  assign restart_hit   = (rx_byte == hdr0);
  assign restart_stage = restart_hit ? ST_H2 : ST_H1;
  assign acc_shift     = {rx_byte, acc_r[VALUE_W-1:BYTE_W]};
  assign byte_ext      = {{(VALUE_W-BYTE_W){1'b0}}, rx_byte};
  assign dbl_pos       = offset_r - OFF_FIRST;

  // Compare against the eight codes, then pick the first hit
  always_comb begin
    for (int k = 0; k < NUM_CODES; k++) begin
      code_hit[k] = (codes_r[k*BYTE_W +: BYTE_W] == rx_byte);
    end
  end

  always_comb begin
    code_found = 1'b1;
    code_kind  = KIND_FEEDBACK;
    if (code_hit[0])      code_kind = KIND_HOME;
    else if (code_hit[1]) code_kind = KIND_MAPPING;
    else if (code_hit[2]) code_kind = KIND_MOVE;
    else if (code_hit[3]) code_kind = KIND_RUN;
    else if (code_hit[4]) code_kind = KIND_REQUEST;
    else if (code_hit[5]) code_kind = KIND_SEND;
    else if (code_hit[6]) code_kind = KIND_MOTOR;
    else if (code_hit[7]) code_kind = KIND_WELDER;
    else if (rx_byte == fb_code_r) code_kind = KIND_FEEDBACK;
    else code_found = 1'b0;
  end

  // Next state and result for the byte at the head of the input register
  always_comb begin
    stage_nxt    = stage_r;
    kind_nxt     = kind_r;
    offset_nxt   = offset_r;
    fcount_nxt   = fcount_r;
    acc_nxt      = acc_r;
    result       = '0;
    result.kind  = kind_r;
    case (stage_r)
      ST_H2: begin
        stage_nxt = (rx_byte == hdr1) ? ST_H3 : restart_stage;
      end
      ST_H3: begin
        if (rx_byte == hdr2) begin
          stage_nxt  = ST_CODE;
          offset_nxt = OFF_CODE;
        end else if (hdr0 == hdr1 && rx_byte == hdr1) begin
          // Repeated header byte keeps the two-byte partial match
          stage_nxt = ST_H3;
        end else begin
          stage_nxt = restart_stage;
        end
      end
      ST_CODE: begin
        if (!code_found) begin
          stage_nxt = restart_stage;
        end else begin
          kind_nxt   = code_kind;
          fcount_nxt = '0;
          acc_nxt    = '0;
          offset_nxt = OFF_FIRST;
          if (code_kind == KIND_HOME || code_kind == KIND_MAPPING ||
              code_kind == KIND_RUN || code_kind == KIND_REQUEST) begin
            stage_nxt    = ST_H1;
            result.emit  = 1'b1;
            result.kind  = code_kind;
            result.index = IDX_NONE;
            result.last  = 1'b1;
          end else begin
            stage_nxt = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        offset_nxt = offset_r + 7'd1;
        if (kind_r == KIND_MOVE) begin
          if (offset_r < OFF_MOVE_VAL) begin
            fcount_nxt   = fcount_r + 4'd1;
            result.emit  = 1'b1;
            result.index = fcount_r;
            result.value = byte_ext;
          end else begin
            acc_nxt = acc_shift;
            if (offset_r >= OFF_MOVE_END) begin
              stage_nxt    = ST_H1;
              result.emit  = 1'b1;
              result.index = IDX_MOVE_VAL;
              result.value = acc_shift;
              result.last  = 1'b1;
            end
          end
        end else if (kind_r == KIND_SEND) begin
          if (offset_r <= OFF_SEND_DBL_END) begin
            acc_nxt = acc_shift;
            // Eighth byte of a double completes the field
            if (dbl_pos[2:0] == 3'd7) begin
              fcount_nxt   = fcount_r + 4'd1;
              result.emit  = 1'b1;
              result.index = fcount_r;
              result.value = acc_shift;
            end
          end else if (offset_r == OFF_SEND_GAP) begin
            result.emit = 1'b0;
          end else if (offset_r == OFF_SEND_POINT) begin
            result.emit  = 1'b1;
            result.index = IDX_SEND_POINT;
            result.value = byte_ext;
          end else if (offset_r == OFF_SEND_PATTERN) begin
            result.emit  = 1'b1;
            result.index = IDX_SEND_PATTERN;
            result.value = byte_ext;
          end else begin
            stage_nxt    = ST_H1;
            result.emit  = 1'b1;
            result.index = IDX_SEND_SPEED;
            result.value = byte_ext;
            result.last  = 1'b1;
          end
        end else if (kind_r == KIND_MOTOR || kind_r == KIND_WELDER ||
                     kind_r == KIND_FEEDBACK) begin
          stage_nxt    = ST_H1;
          result.emit  = 1'b1;
          result.index = IDX_NONE;
          result.value = byte_ext;
          result.last  = 1'b1;
        end else begin
          stage_nxt = ST_H1;
        end
      end
      default: begin
        // Hunting for the first header byte
        stage_nxt = restart_stage;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= ST_H1;
      kind_r   <= '0;
      offset_r <= '0;
      fcount_r <= '0;
      acc_r    <= '0;
    end else if (advance) begin
      stage_r  <= stage_nxt;
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
      fcount_r <= fcount_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

### design/cfd_output_stage.sv
// Output register: holds one result record until the consumer takes it.
`default_nettype none
module cfd_output_stage
  import cfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire cfd_result_t           result,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] command_kind, [7:4] field_index,
                                                 // [71:8] field_value
  output logic                       out_tlast   // last_field
);

  logic                  valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [INDEX_W-1:0]    index_r;
  logic [VALUE_W-1:0]    value_r;
  logic                  last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= result.emit;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      kind_r  <= result.kind;
      index_r <= result.index;
      value_r <= result.value;
      last_r  <= result.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {value_r, index_r, kind_r};
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### design/cfd_checker.sv
// Port-level checks of the command frame decoder, bound to the top level.
`default_nettype none
module cfd_checker
  import cfd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // A stalled result transaction keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Kind and field number stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= KIND_FEEDBACK && out_tdata[7:4] <= IDX_SEND_SPEED)
    else $error("kind or field number out of range");

  // Commands without payload give one empty, final record
  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == KIND_HOME || out_tdata[3:0] == KIND_MAPPING ||
                   out_tdata[3:0] == KIND_RUN || out_tdata[3:0] == KIND_REQUEST)
    |-> out_tlast && out_tdata[7:4] == IDX_NONE && out_tdata[71:8] == '0)
    else $error("payload-free command record malformed");

  // Single-byte commands carry field 0 as the final field with a byte value
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == KIND_MOTOR || out_tdata[3:0] == KIND_WELDER ||
                   out_tdata[3:0] == KIND_FEEDBACK)
    |-> out_tlast && out_tdata[7:4] == IDX_NONE && out_tdata[71:16] == '0)
    else $error("single-byte command record malformed");

  // The send command ends on its speed field, the move command on field 2
  a_last_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == KIND_SEND || out_tdata[3:0] == KIND_MOVE)
    |-> out_tlast == (out_tdata[7:4] == IDX_SEND_SPEED || (out_tdata[3:0] == KIND_MOVE &&
                                                          out_tdata[7:4] == IDX_MOVE_VAL)))
    else $error("final field flag wrong");

endmodule

bind command_frame_decoder_core cfd_checker u_cfd_checker (.*);
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the command frame decoder core.
module tb_top;
  import cfd_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_BYTES = 180;
  localparam int RESET_ROWS  = 4;
  localparam int DIR_ROWS    = 27;
  localparam int SETTLE_CYC  = 8;
  localparam int NUM_KINDS   = 9;

  // Index past the last register; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Parser stages of the predictor
  typedef enum logic [2:0] {HUNT1, HUNT2, HUNT3, GET_CODE, PAYLOAD} parse_stage_t;

  // One decoded field record with the fields of the output stream, kind first
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    logic               last;
  } frame_rec_t;

  // Directed rows either carry their result or defer to the predictor
  typedef enum bit {FROM_MODEL, TYPED} row_check_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    row_check_t        chk;
    frame_rec_t        want;
  } step_row_t;

  localparam frame_rec_t NO_REC = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;   // [3:0] command_kind, [7:4] field_index, [71:8] field_value
  logic                  out_tlast;   // last_field
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the parser state
  logic [HDR_W-1:0]    hdr_reg = '0;
  logic [63:0]         codes_reg = '0;
  logic [BYTE_W-1:0]   fb_code_reg = '0;
  parse_stage_t        p_stage = HUNT1;
  logic [KIND_W-1:0]   p_kind = '0;
  logic [OFFSET_W-1:0] p_off = '0;
  logic [INDEX_W-1:0]  p_cnt = '0;
  logic [VALUE_W-1:0]  p_acc = '0;

  frame_rec_t pending_fields[$];
  step_row_t  dir_rows[0:DIR_ROWS-1];
  frame_rec_t got_rec, want_rec;
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         settings_loaded = 0;
  int         kind_hits[0:NUM_KINDS-1];
  bit         src_quiet = 1'b0;
  bit         sink_quiet = 1'b0;
  int         sink_wait = 0;

  command_frame_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic frame_rec_t make_rec(input logic [KIND_W-1:0] kind,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] value,
                                          input logic last);
    return {kind, idx, value, last};
  endfunction

  function automatic step_row_t dir_step(input logic [BYTE_W-1:0] rx, input row_check_t chk,
                                         input frame_rec_t want);
    return {rx, chk, want};
  endfunction

  // Header byte k, first byte in the top bits
  function automatic logic [BYTE_W-1:0] hdr_byte(input int k);
    return hdr_reg[HDR_W - 1 - 8 * k -: 8];
  endfunction

  function automatic logic [BYTE_W-1:0] code_of(input int k);
    if (k < NUM_CODES) return codes_reg[8 * k +: 8];
    return fb_code_reg;
  endfunction

  function automatic int payload_bytes(input int k);
    case (4'(k))
      KIND_HOME, KIND_MAPPING, KIND_RUN, KIND_REQUEST: return 0;
      KIND_MOVE: return int'(OFF_MOVE_END) - int'(OFF_FIRST) + 1;
      KIND_SEND: return int'(OFF_SEND_PATTERN) + 2 - int'(OFF_FIRST);
      default:   return 1;
    endcase
  endfunction

  // Payload content, often a header byte so that payloads look like headers
  function automatic logic [BYTE_W-1:0] payload_byte();
    if ($urandom_range(0, 3) == 0) return hdr_byte($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // A byte that breaks a header may itself start the next one
  function automatic void rehunt(input logic [BYTE_W-1:0] b);
    p_stage = (b == hdr_byte(0)) ? HUNT2 : HUNT1;
  endfunction

  // Advance the parser by one byte; returns 1 when a field record completes
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output frame_rec_t rec);
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] off;
    bit                  found;
    rec   = NO_REC;
    kind  = '0;
    found = 1'b0;
    case (p_stage)
      HUNT2: begin
        if (b == hdr_byte(1)) p_stage = HUNT3;
        else rehunt(b);
        return 1'b0;
      end
      HUNT3: begin
        if (b == hdr_byte(2)) begin
          p_stage = GET_CODE;
          p_off   = OFF_CODE;
        end else if (!(hdr_byte(0) == hdr_byte(1) && b == hdr_byte(1))) begin
          rehunt(b);
        end
        return 1'b0;
      end
      GET_CODE: begin
        // first matching code in priority order wins
        for (int k = 0; k < NUM_CODES; k++) begin
          if (!found && codes_reg[8 * k +: 8] == b) begin
            found = 1'b1;
            kind  = 4'(k);
          end
        end
        if (!found && b == fb_code_reg) begin
          found = 1'b1;
          kind  = KIND_FEEDBACK;
        end
        if (!found) begin
          rehunt(b);
          return 1'b0;
        end
        p_kind = kind;
        p_cnt  = '0;
        p_acc  = '0;
        p_off  = OFF_FIRST;
        if (kind == KIND_HOME || kind == KIND_MAPPING || kind == KIND_RUN ||
            kind == KIND_REQUEST) begin
          p_stage = HUNT1;
          rec = make_rec(kind, IDX_NONE, '0, 1'b1);
          return 1'b1;
        end
        p_stage = PAYLOAD;
        return 1'b0;
      end
      PAYLOAD: begin
        off   = p_off;
        p_off = p_off + 1'b1;
        case (p_kind)
          KIND_MOVE: begin
            if (off < OFF_MOVE_VAL) begin
              rec   = make_rec(p_kind, p_cnt, {56'h0, b}, 1'b0);
              p_cnt = p_cnt + 1'b1;
              return 1'b1;
            end
            p_acc = {b, p_acc[VALUE_W-1:8]};
            if (off >= OFF_MOVE_END) begin
              p_stage = HUNT1;
              rec = make_rec(p_kind, IDX_MOVE_VAL, p_acc, 1'b1);
              return 1'b1;
            end
            return 1'b0;
          end
          KIND_SEND: begin
            // nine doubles, one skipped byte, then three byte fields
            if (off <= OFF_SEND_DBL_END) begin
              p_acc = {b, p_acc[VALUE_W-1:8]};
              if (((off - OFF_FIRST) & 7'd7) == 7'd7) begin
                rec   = make_rec(p_kind, p_cnt, p_acc, 1'b0);
                p_cnt = p_cnt + 1'b1;
                return 1'b1;
              end
              return 1'b0;
            end
            if (off == OFF_SEND_GAP) return 1'b0;
            if (off == OFF_SEND_POINT) begin
              rec = make_rec(p_kind, IDX_SEND_POINT, {56'h0, b}, 1'b0);
              return 1'b1;
            end
            if (off == OFF_SEND_PATTERN) begin
              rec = make_rec(p_kind, IDX_SEND_PATTERN, {56'h0, b}, 1'b0);
              return 1'b1;
            end
            p_stage = HUNT1;
            rec = make_rec(p_kind, IDX_SEND_SPEED, {56'h0, b}, 1'b1);
            return 1'b1;
          end
          KIND_MOTOR, KIND_WELDER, KIND_FEEDBACK: begin
            p_stage = HUNT1;
            rec = make_rec(p_kind, IDX_NONE, {56'h0, b}, 1'b1);
            return 1'b1;
          end
          default: begin
            p_stage = HUNT1;
            return 1'b0;
          end
        endcase
      end
      default: begin
        rehunt(b);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void report_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Send one byte after a random gap and queue what it should produce
  task automatic push_byte(input logic [BYTE_W-1:0] b, input row_check_t chk,
                           input frame_rec_t given);
    int         gap;
    bit         hit;
    frame_rec_t model_rec;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    hit = decode_byte(b, model_rec);
    if (chk == TYPED) pending_fields.push_back(given);
    else if (hit) pending_fields.push_back(model_rec);
  endtask

  // Stop sending, wait for every pending field, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes follow without a gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_HEADER:   hdr_reg     = data[HDR_W-1:0];
      CFG_IDX_CODES:    codes_reg   = data;
      CFG_IDX_FEEDBACK: fb_code_reg = data[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // Unused upper bits carry noise that the block has to drop
  task automatic load_settings(input logic [HDR_W-1:0] h, input logic [63:0] codes,
                               input logic [BYTE_W-1:0] fb);
    settle();
    write_reg(CFG_IDX_HEADER, {$urandom, 8'($urandom), h});
    write_reg(CFG_IDX_CODES, codes);
    write_reg(CFG_IDX_FEEDBACK, {$urandom, 24'($urandom), fb});
    write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // One random sequence: mostly good frames, some noise and broken ones
  task automatic send_frame();
    int style;
    int k;
    int n;
    style = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) src_quiet = !src_quiet;
    if (style == 7) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom_range(0, 255)), FROM_MODEL, NO_REC);
    end else if (style == 8) begin
      // header cut short by a stray byte
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) push_byte(hdr_byte(i), FROM_MODEL, NO_REC);
      push_byte(8'($urandom_range(0, 255)), FROM_MODEL, NO_REC);
    end else begin
      for (int i = 0; i < 3; i++) push_byte(hdr_byte(i), FROM_MODEL, NO_REC);
      if (style == 9) begin
        // arbitrary code byte, usually not a configured one
        push_byte(8'($urandom_range(0, 255)), FROM_MODEL, NO_REC);
      end else begin
        k = $urandom_range(0, NUM_KINDS - 1);
        push_byte(code_of(k), FROM_MODEL, NO_REC);
        n = payload_bytes(k);
        repeat (n) push_byte(payload_byte(), FROM_MODEL, NO_REC);
      end
    end
  endtask

  // Result sink: random stall after each transaction, with quiet stretches
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 8);
    end
    if (sink_wait > 0) begin
      sink_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending field
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rec = {out_tdata[KIND_W-1:0], out_tdata[KIND_W +: INDEX_W],
                 out_tdata[KIND_W + INDEX_W +: VALUE_W], out_tlast};
      if (got_rec.kind < NUM_KINDS) kind_hits[got_rec.kind]++;
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected result kind %h index %h value %h last %b", $time,
                 got_rec.kind, got_rec.idx, got_rec.value, got_rec.last);
        mismatches++;
      end else begin
        want_rec = pending_fields.pop_front();
        report_field("command_kind", want_rec.kind, got_rec.kind);
        report_field("field_index", want_rec.idx, got_rec.idx);
        report_field("field_value", want_rec.value, got_rec.value);
        report_field("last_field", want_rec.last, got_rec.last);
      end
    end
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 400000);
    $display("%0t: watchdog expired with %0d fields pending", $time, pending_fields.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [HDR_W-1:0]  h;
    logic [63:0]       codes;
    logic [BYTE_W-1:0] fb;
    logic [BYTE_W-1:0] lead;
    int                phase_goal;
    for (int i = 0; i < NUM_KINDS; i++) kind_hits[i] = 0;

    // Rows 0-3 run on reset values: all-zero header and codes decode as home.
    // The rest use header AA AA 55, codes 10..16 with welder sharing the motor
    // code, and feedback 18.
    dir_rows = '{
      dir_step(8'h00, FROM_MODEL, NO_REC),
      dir_step(8'h00, FROM_MODEL, NO_REC),
      dir_step(8'h00, FROM_MODEL, NO_REC),
      dir_step(8'h00, TYPED, make_rec(KIND_HOME, IDX_NONE, '0, 1'b1)),
      // repeated first header byte keeps the partial match, then unknown code
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'h55, FROM_MODEL, NO_REC),
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      // the rejected code byte opens the next header; shared code goes to motor
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'h55, FROM_MODEL, NO_REC),
      dir_step(8'h16, FROM_MODEL, NO_REC),
      dir_step(8'hFF, TYPED, make_rec(KIND_MOTOR, IDX_NONE, 64'hFF, 1'b1)),
      // move frame: two byte fields and one little-endian double
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'hAA, FROM_MODEL, NO_REC),
      dir_step(8'h55, FROM_MODEL, NO_REC),
      dir_step(8'h12, FROM_MODEL, NO_REC),
      dir_step(8'h00, TYPED, make_rec(KIND_MOVE, IDX_NONE, '0, 1'b0)),
      dir_step(8'hFF, TYPED, make_rec(KIND_MOVE, 4'd1, 64'hFF, 1'b0)),
      dir_step(8'h01, FROM_MODEL, NO_REC),
      dir_step(8'h23, FROM_MODEL, NO_REC),
      dir_step(8'h45, FROM_MODEL, NO_REC),
      dir_step(8'h67, FROM_MODEL, NO_REC),
      dir_step(8'h89, FROM_MODEL, NO_REC),
      dir_step(8'hAB, FROM_MODEL, NO_REC),
      dir_step(8'hCD, FROM_MODEL, NO_REC),
      dir_step(8'hEF, TYPED, make_rec(KIND_MOVE, IDX_MOVE_VAL, 64'hEFCD_AB89_6745_2301, 1'b1))
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == RESET_ROWS) load_settings(24'hAAAA55, 64'h1616_1514_1312_1110, 8'h18);
      push_byte(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].want);
    end

    // Random part, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      h     = 24'($urandom);
      codes = {$urandom, $urandom};
      fb    = 8'($urandom);
      case (ph)
        1: begin
          // everything all-ones: every code collides, only home decodes
          h     = '1;
          codes = '1;
          fb    = '1;
        end
        2: begin
          // all-zero header, codes overlapping the header bytes
          h     = '0;
          codes = 64'h0706_0504_0302_0100;
          fb    = 8'h08;
        end
        3: begin
          lead = 8'($urandom);
          h    = {lead, lead, 8'($urandom)};
        end
        4: begin
          // welder shadowed by move, feedback shadowed by home
          codes[63:56] = codes[23:16];
          fb           = codes[7:0];
        end
        default: ;
      endcase
      load_settings(h, codes, fb);
      phase_goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_goal) send_frame();
    end

    settle();
    $display("Sent %0d bytes under %0d register settings, directed and random frames.",
             bytes_sent, settings_loaded);
    $display("Records by kind home..feedback: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
             kind_hits[5], kind_hits[6], kind_hits[7], kind_hits[8]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
